@@ rtl/core/lcsp_pkg.sv @@
// ----------------------------------------------------------------------------
// lcsp_pkg
// Types, codes and constants shared by the lane change speed planner.
// ----------------------------------------------------------------------------
package lcsp_pkg;

    localparam int LANE_COUNT_DEF = 3;

    localparam int LANE_W   = 3;
    localparam int SPEED_W  = 14;
    localparam int POS_W    = 21;
    localparam int LAT_W    = 14;
    localparam int VEL_W    = 16;
    localparam int SQ_W     = 32;
    localparam int WIDTH_W  = 12;
    localparam int GAP_W    = 16;
    localparam int STEP_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [LANE_W-1:0]  LANE_RESET        = 3'd1;
    localparam logic [SPEED_W-1:0] SPEED_MAX         = 14'h3FFF;
    localparam logic [WIDTH_W-1:0] LANE_WIDTH_RESET  = 12'd1024;
    localparam logic [GAP_W-1:0]   FRONT_GAP_RESET   = 16'd7680;
    localparam logic [GAP_W-1:0]   REAR_GAP_RESET    = 16'd5120;
    localparam logic [STEP_W-1:0]  SPEED_STEP_RESET  = 10'd57;
    localparam logic [SPEED_W-1:0] SPEED_LIMIT_RESET = 14'd12672;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LANE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_GAP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REAR_GAP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 3'd4;

    // lane_move codes
    localparam logic [1:0] MOVE_KEEP  = 2'd0;
    localparam logic [1:0] MOVE_LEFT  = 2'd1;
    localparam logic [1:0] MOVE_RIGHT = 2'd2;

    // speed_change codes
    localparam logic [1:0] CHG_NONE  = 2'd0;
    localparam logic [1:0] CHG_SLOW  = 2'd1;
    localparam logic [1:0] CHG_ACCEL = 2'd2;

    typedef struct packed {
        logic signed [LAT_W-1:0] car_lateral;
        logic [POS_W-1:0]        car_along;
        logic signed [VEL_W-1:0] car_vel_x;
        logic signed [VEL_W-1:0] car_vel_y;
        logic [POS_W-1:0]        ego_along;
        logic                    car_present;
        logic                    frame_end;
    } t_in_item;

    typedef struct packed {
        logic [LANE_W-1:0]  lane_now;
        logic [SPEED_W-1:0] target_speed;
        logic               blocked_ahead;
        logic [1:0]         lane_move;
        logic [1:0]         speed_change;
    } t_out_item;

    typedef struct packed {
        logic [WIDTH_W-1:0] lane_width;
        logic [GAP_W-1:0]   front_gap;
        logic [GAP_W-1:0]   rear_gap;
        logic [STEP_W-1:0]  speed_step;
        logic [SPEED_W-1:0] speed_limit;
    } t_cfg;

    // registered car, speed already squared
    typedef struct packed {
        logic signed [LAT_W-1:0] car_lateral;
        logic [POS_W-1:0]        car_along;
        logic [POS_W-1:0]        ego_along;
        logic [SQ_W-1:0]         speed_sq;
        logic                    car_present;
        logic                    frame_end;
    } t_stage_item;

endpackage

@@ rtl/core/lcsp_if.sv @@
// ----------------------------------------------------------------------------
// lcsp_in_if / lcsp_out_if
// Valid/ready channels for car items and planner results.
// ----------------------------------------------------------------------------
interface lcsp_in_if;
    logic               valid;
    logic               ready;
    lcsp_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lcsp_out_if;
    logic                valid;
    logic                ready;
    lcsp_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/lcsp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lcsp_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module lcsp_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lcsp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lcsp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output lcsp_pkg::t_cfg                      o_cfg
);
    import lcsp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lane_width  <= LANE_WIDTH_RESET;
            r_cfg.front_gap   <= FRONT_GAP_RESET;
            r_cfg.rear_gap    <= REAR_GAP_RESET;
            r_cfg.speed_step  <= SPEED_STEP_RESET;
            r_cfg.speed_limit <= SPEED_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LANE_WIDTH:  r_cfg.lane_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_FRONT_GAP:   r_cfg.front_gap   <= i_cfg_data[GAP_W-1:0];
                CFG_REAR_GAP:    r_cfg.rear_gap    <= i_cfg_data[GAP_W-1:0];
                CFG_SPEED_STEP:  r_cfg.speed_step  <= i_cfg_data[STEP_W-1:0];
                CFG_SPEED_LIMIT: r_cfg.speed_limit <= i_cfg_data[SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/lcsp_input_stage.sv @@
// ----------------------------------------------------------------------------
// lcsp_input_stage
// Input register; squares the car velocity on the way in.
// ----------------------------------------------------------------------------
module lcsp_input_stage (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    lcsp_in_if.sink                 i_item,
    input  logic                    i_take,
    output logic                    o_valid,
    output lcsp_pkg::t_stage_item   o_item
);
    import lcsp_pkg::*;

    logic                      r_valid;
    t_stage_item               r_item;
    t_stage_item               n_item;
    logic signed [2*VEL_W-1:0] sq_x;
    logic signed [2*VEL_W-1:0] sq_y;

    always_comb begin
        sq_x = (2*VEL_W)'(i_item.payload.car_vel_x) * (2*VEL_W)'(i_item.payload.car_vel_x);
        sq_y = (2*VEL_W)'(i_item.payload.car_vel_y) * (2*VEL_W)'(i_item.payload.car_vel_y);
        n_item.car_lateral = i_item.payload.car_lateral;
        n_item.car_along   = i_item.payload.car_along;
        n_item.ego_along   = i_item.payload.ego_along;
        n_item.speed_sq    = SQ_W'($unsigned(sq_x)) + SQ_W'($unsigned(sq_y));
        n_item.car_present = i_item.payload.car_present;
        n_item.frame_end   = i_item.payload.frame_end;
    end

    assign i_item.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/core/lcsp_frame_update.sv @@
// ----------------------------------------------------------------------------
// lcsp_frame_update
// Frame flags, nearest front car, lane/speed decision and result register.
// ----------------------------------------------------------------------------
module lcsp_frame_update #(
    parameter int LANE_COUNT = lcsp_pkg::LANE_COUNT_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lcsp_pkg::t_cfg          i_cfg,
    input  logic                    i_valid,
    input  lcsp_pkg::t_stage_item   i_item,
    output logic                    o_take,
    lcsp_out_if.source              o_result
);
    import lcsp_pkg::*;

    localparam logic [LANE_W-1:0] LastLane = LANE_W'(LANE_COUNT - 1);
    localparam int BND_W = 18;

    logic [LANE_W-1:0]  r_lane,   n_lane;
    logic [SPEED_W-1:0] r_speed,  n_speed;
    logic               r_close,  n_close;
    logic               r_lclear, n_lclear;
    logic               r_rclear, n_rclear;
    logic               r_fseen,  n_fseen;
    logic [POS_W-1:0]   r_fpos,   n_fpos;
    logic [SQ_W-1:0]    r_fsq,    n_fsq;
    logic               r_out_valid;
    t_out_item          r_out,    n_out;

    logic [14:0]              lo_u;
    logic signed [BND_W-1:0]  w_s, d_s, lo_s, hi_s, llo_s, rhi_s;
    logic                     in_own, in_left, in_right;
    logic                     ahead, behind, level, side_block;
    logic [POS_W-1:0]         diff_fwd, diff_back;
    logic [2*SPEED_W-1:0]     r2;
    logic [SPEED_W:0]         sum;
    logic                     out_free;

    // lane bounds around the current lane
    always_comb begin
        lo_u  = 15'(r_lane) * 15'(i_cfg.lane_width);
        w_s   = signed'(BND_W'(i_cfg.lane_width));
        d_s   = BND_W'(i_item.car_lateral);
        lo_s  = signed'(BND_W'(lo_u));
        hi_s  = lo_s + w_s;
        llo_s = lo_s - w_s;
        rhi_s = hi_s + w_s;
        in_own   = (d_s > lo_s) && (d_s < hi_s);
        in_left  = (d_s > llo_s) && (d_s < lo_s);
        in_right = (d_s > hi_s) && (d_s < rhi_s);

        diff_fwd  = i_item.car_along - i_item.ego_along;
        diff_back = i_item.ego_along - i_item.car_along;
        ahead  = (i_item.car_along > i_item.ego_along) &&
                 (diff_fwd < POS_W'(i_cfg.front_gap));
        behind = (i_item.car_along < i_item.ego_along) &&
                 (diff_back < POS_W'(i_cfg.rear_gap));
        level  = (i_item.car_along == i_item.ego_along);
        side_block = ahead || behind || level;
    end

    // take the car, then decide on the last item of a frame
    always_comb begin
        n_close  = r_close;
        n_lclear = r_lclear;
        n_rclear = r_rclear;
        n_fseen  = r_fseen;
        n_fpos   = r_fpos;
        n_fsq    = r_fsq;
        n_lane   = r_lane;
        n_speed  = r_speed;
        r2       = 28'(r_speed) * 28'(r_speed);
        sum      = 15'(r_speed) + 15'(i_cfg.speed_step);
        n_out.blocked_ahead = 1'b0;
        n_out.lane_move     = MOVE_KEEP;
        n_out.speed_change  = CHG_NONE;

        if (i_item.car_present) begin
            if (in_own && ahead) begin
                n_close = 1'b1;
                if (!r_fseen || (i_item.car_along < r_fpos)) begin
                    n_fseen = 1'b1;
                    n_fpos  = i_item.car_along;
                    n_fsq   = i_item.speed_sq;
                end
            end
            if (in_left && side_block) begin
                n_lclear = 1'b0;
            end
            if (in_right && side_block) begin
                n_rclear = 1'b0;
            end
        end

        n_out.blocked_ahead = n_close;
        if (n_close) begin
            if ((r_lane != '0) && n_lclear) begin
                n_lane = r_lane - 1'b1;
                n_out.lane_move = MOVE_LEFT;
            end else if ((r_lane < LastLane) && n_rclear) begin
                n_lane = r_lane + 1'b1;
                n_out.lane_move = MOVE_RIGHT;
            end
            if ((n_fsq != '0) && (SQ_W'(r2) >= n_fsq)) begin
                n_speed = (r_speed > SPEED_W'(i_cfg.speed_step)) ?
                          r_speed - SPEED_W'(i_cfg.speed_step) : '0;
                n_out.speed_change = CHG_SLOW;
            end
        end else if (r_speed < i_cfg.speed_limit) begin
            n_speed = sum[SPEED_W] ? SPEED_MAX : sum[SPEED_W-1:0];
            n_out.speed_change = CHG_ACCEL;
        end
        n_out.lane_now     = n_lane;
        n_out.target_speed = n_speed;
    end

    assign out_free = !r_out_valid || o_result.ready;
    assign o_take   = i_valid && (!i_item.frame_end || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane   <= LANE_RESET;
            r_speed  <= '0;
            r_close  <= 1'b0;
            r_lclear <= 1'b1;
            r_rclear <= 1'b1;
            r_fseen  <= 1'b0;
            r_fpos   <= '0;
            r_fsq    <= '0;
        end else if (o_take) begin
            if (i_item.frame_end) begin
                r_lane   <= n_lane;
                r_speed  <= n_speed;
                r_close  <= 1'b0;
                r_lclear <= 1'b1;
                r_rclear <= 1'b1;
                r_fseen  <= 1'b0;
                r_fpos   <= '0;
                r_fsq    <= '0;
            end else begin
                r_close  <= n_close;
                r_lclear <= n_lclear;
                r_rclear <= n_rclear;
                r_fseen  <= n_fseen;
                r_fpos   <= n_fpos;
                r_fsq    <= n_fsq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && i_item.frame_end) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_item.frame_end) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

endmodule

@@ rtl/core/lane_change_speed_planner_core.sv @@
// ----------------------------------------------------------------------------
// lane_change_speed_planner_core
// Per-frame lane change and reference speed planner over tracked cars.
// ----------------------------------------------------------------------------
// Takes one car transaction per cycle; a frame ends with the item that has
// frame_end set, and that item yields one result transaction through the input
// register and then the result register. Other items yield none.
// Throughput is set by the frame update loop: one item per cycle
// while the result register is free or being drained; a frame_end item waits
// in the input register only while a previous result has not been taken.
// Configuration writes are taken at any time and belong between frames.
module lane_change_speed_planner_core #(
    parameter int LANE_COUNT = lcsp_pkg::LANE_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lcsp_in_if.sink                          i_item,
    lcsp_out_if.source                       o_result,
    input  logic                             i_cfg_we,
    input  logic [lcsp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lcsp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lcsp_pkg::*;

    t_cfg        cfg;
    t_stage_item stage_item;
    logic        stage_valid;
    logic        stage_take;

    lcsp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lcsp_input_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_take  (stage_take),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    lcsp_frame_update #(
        .LANE_COUNT (LANE_COUNT)
    ) u_upd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (stage_valid),
        .i_item   (stage_item),
        .o_take   (stage_take),
        .o_result (o_result)
    );

endmodule

@@ rtl/core/lcsp_checker.sv @@
// ----------------------------------------------------------------------------
// lcsp_checker
// Port-level checks on planner results, bound to the top level.
// ----------------------------------------------------------------------------
module lcsp_checker #(
    parameter int LANE_COUNT = lcsp_pkg::LANE_COUNT_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input lcsp_pkg::t_out_item  i_out
);
    import lcsp_pkg::*;

    localparam logic [LANE_W-1:0] LastLane = LANE_W'(LANE_COUNT - 1);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out))
        else $error("result changed while stalled");

    a_lane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out.lane_now <= LastLane)
        else $error("lane out of range");

    a_move_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out.lane_move != MOVE_KEEP || i_out.speed_change == CHG_SLOW)
        |-> i_out.blocked_ahead)
        else $error("lane move or slowing without car ahead");

    a_accel_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.speed_change == CHG_ACCEL
        |-> !i_out.blocked_ahead && i_out.lane_move == MOVE_KEEP)
        else $error("accelerated while blocked");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind lane_change_speed_planner_core lcsp_checker #(
    .LANE_COUNT (LANE_COUNT)
) u_lcsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out       (o_result.payload)
);
